### sv/itoa_pkg.sv
// Shared types, constants and helper functions for the integer to ASCII converter.
`timescale 1ns / 1ps
`default_nettype none
package itoa_pkg;

	// Default sizes handed to the top level
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF  = 32;
	localparam int FIFO_DEPTH      = 2;

	// Configuration port
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;
	localparam int RADIX_W = 6;
	localparam logic REG_RADIX = 1'b0;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

	// ASCII codes
	localparam logic [7:0] CHAR_MINUS    = 8'h2D;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_LETTER_A = 8'h61;

	// One output transaction
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_item_t;

	// Back end sequencer
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SIGN,
		BK_READ,
		BK_EMIT
	} back_state_t;

	// Clamp the programmed radix into 2..36
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] e;
		e = r;
		if (r < RADIX_MIN)
			e = RADIX_MIN;
		else if (r > RADIX_MAX)
			e = RADIX_MAX;
		return e;
	endfunction

	// Digit value to '0'..'9' or 'a'..'z'
	function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [7:0] c;
		if (d < DIGIT_TEN)
			c = CHAR_ZERO + {2'b00, d};
		else
			c = CHAR_LETTER_A + {2'b00, d} - {2'b00, DIGIT_TEN};
		return c;
	endfunction

endpackage
`default_nettype wire

### sv/itoa_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module itoa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### sv/itoa_fifo.sv
// Small register FIFO used for the work queue and the output queue.
`timescale 1ns / 1ps
`default_nettype none
module itoa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (do_rd)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

### sv/itoa_front.sv
// Front end: accepts values, splits off the sign and forms the magnitude.
`timescale 1ns / 1ps
`default_nettype none
module itoa_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        full,
	output logic                        q_push,
	output logic      [VALUE_WIDTH:0]   q_item,
	input  wire logic                   q_full
);

	logic                   valid_s1;
	logic                   neg_s1;
	logic [VALUE_WIDTH-1:0] mag_s1;
	logic                   in_take;
	logic                   neg;

	assign full    = valid_s1 && q_full;
	assign in_take = push && !full;
	assign neg     = value[VALUE_WIDTH-1];
	assign q_push  = valid_s1;
	assign q_item  = {neg_s1, mag_s1};

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (!q_full)
			valid_s1 <= 1'b0;
	end

	// Sign and magnitude; the most negative value wraps to its unsigned magnitude
	always_ff @(posedge clk) begin
		if (in_take) begin
			neg_s1 <= neg;
			mag_s1 <= neg ? (~value + VALUE_WIDTH'(1)) : value;
		end
	end

endmodule
`default_nettype wire

### sv/itoa_divider.sv
// Restoring divider, one quotient bit per cycle, by a small divisor.
`timescale 1ns / 1ps
`default_nettype none
module itoa_divider
	import itoa_pkg::RADIX_W;
#(
	parameter int WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [WIDTH-1:0]   dividend,
	input  wire logic [RADIX_W-1:0] divisor,
	output logic                    done,
	output logic      [WIDTH-1:0]   quotient,
	output logic      [RADIX_W-1:0] remainder
);

	import itoa_pkg::*;

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0]   quo_q;
	logic [RADIX_W-1:0] rem_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [RADIX_W:0]   shifted;
	logic [RADIX_W:0]   diff;
	logic               ge;

	// One trial subtraction
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign ge      = (shifted >= {1'b0, divisor});
	assign diff    = shifted - {1'b0, divisor};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[WIDTH-2:0], ge};
			rem_q <= ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < divisor))
		else $error("remainder not below divisor");
`endif

endmodule
`default_nettype wire

### sv/itoa_back.sv
// Back end: divides out the digits, stores them, then emits the characters.
`timescale 1ns / 1ps
`default_nettype none
module itoa_back
	import itoa_pkg::RADIX_W;
	import itoa_pkg::out_item_t;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [RADIX_W-1:0]     radix,
	input  wire logic                   q_empty,
	input  wire logic [VALUE_WIDTH:0]   q_item,
	output logic                        q_pop,
	input  wire logic                   o_full,
	output logic                        o_push,
	output out_item_t                   o_item
);

	import itoa_pkg::*;

	localparam int AW    = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	back_state_t            state_q, state_d;
	logic                   neg_q;
	logic [RADIX_W-1:0]     eradix_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_next;
	logic [CNT_W-1:0]       rd_idx;

	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quo;
	logic [RADIX_W-1:0]     div_rem;

	logic                   ram_we;
	logic                   ram_re;
	logic [RADIX_W-1:0]     ram_rdata;

	logic                   load_item;
	logic                   last_digit;

	assign count_next = count_q + CNT_W'(1);
	assign rd_idx     = count_q - CNT_W'(1);
	assign last_digit = (count_q == CNT_W'(1));

	itoa_divider #(
		.WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (eradix_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	itoa_ram #(
		.WIDTH(RADIX_W),
		.DEPTH(MAX_DIGITS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(div_rem),
		.re   (ram_re),
		.raddr(rd_idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and strobes
	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		load_item    = 1'b0;
		div_start    = 1'b0;
		div_dividend = q_item[VALUE_WIDTH-1:0];
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		o_push       = 1'b0;
		o_item       = '{character: CHAR_MINUS, last: 1'b0};
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					load_item = 1'b1;
					div_start = 1'b1;
					state_d   = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_done) begin
					ram_we = 1'b1;
					if (div_quo == '0 || count_next == CNT_W'(MAX_DIGITS)) begin
						state_d = neg_q ? BK_SIGN : BK_READ;
					end else begin
						div_start    = 1'b1;
						div_dividend = div_quo;
					end
				end
			end
			BK_SIGN: begin
				if (!o_full) begin
					o_push  = 1'b1;
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				ram_re  = 1'b1;
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				o_item = '{character: digit_char(ram_rdata), last: last_digit};
				if (!o_full) begin
					o_push  = 1'b1;
					state_d = last_digit ? BK_IDLE : BK_READ;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Digit count: up while dividing, down while emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (load_item)
			count_q <= '0;
		else if (ram_we)
			count_q <= count_next;
		else if (o_push && state_q == BK_EMIT)
			count_q <= rd_idx;
	end

	// Per transaction sign and radix
	always_ff @(posedge clk) begin
		if (load_item) begin
			neg_q    <= q_item[VALUE_WIDTH];
			eradix_q <= eff_radix(radix);
		end
	end

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		o_push |-> !o_full)
		else $error("output push while full");
	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(o_push && o_item.last) |=> (state_q == BK_IDLE))
		else $error("sequencer did not return to idle after last character");
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count out of range");
`endif

endmodule
`default_nettype wire

### sv/integer_to_ascii_radix.sv
// Top level: signed integer to ASCII text in a programmable radix.
// Each digit costs one pass of the bit-serial divider, and a large decimal value has 10 digits;
// each character then goes through the digit store's registered read, BK_READ then BK_EMIT.
// One value is converted at a time; up to three more wait in the input stage and queue.
// Reset: asynchronous active low; queues empty, radix back to 10.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_ascii_radix
	import itoa_pkg::DATA_W;
	import itoa_pkg::ADDR_W;
	import itoa_pkg::VALUE_WIDTH_DEF;
	import itoa_pkg::MAX_DIGITS_DEF;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input queue side
	input  wire logic                   push,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        full,
	// result queue side
	input  wire logic                   pop,
	output logic                        empty,
	output logic      [7:0]             character,
	output logic                        last,
	// configuration
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [DATA_W-1:0]      pwdata,
	output logic      [DATA_W-1:0]      prdata,
	output logic                        pready
);

	import itoa_pkg::*;

	localparam int OW = $bits(out_item_t);

	logic [RADIX_W-1:0]     radix_q;
	logic                   q_push, q_full, q_pop, q_empty;
	logic [VALUE_WIDTH:0]   q_wdata, q_rdata;
	logic                   o_push, o_full;
	out_item_t              o_item;
	logic [OW-1:0]          o_rdata;
	out_item_t              o_head;
	logic                   reg_sel;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_RADIX);
	assign prdata  = reg_sel ? {{(DATA_W - RADIX_W){1'b0}}, radix_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= RADIX_RESET;
		else if (psel && penable && pwrite && pready && reg_sel)
			radix_q <= pwdata[RADIX_W-1:0];
	end

	itoa_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.value (value),
		.full  (full),
		.q_push(q_push),
		.q_item(q_wdata),
		.q_full(q_full)
	);

	// Work queue between front and back
	itoa_fifo #(
		.WIDTH(VALUE_WIDTH + 1),
		.DEPTH(FIFO_DEPTH)
	) u_work_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	itoa_back #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.radix  (radix_q),
		.q_empty(q_empty),
		.q_item (q_rdata),
		.q_pop  (q_pop),
		.o_full (o_full),
		.o_push (o_push),
		.o_item (o_item)
	);

	// Result queue
	itoa_fifo #(
		.WIDTH(OW),
		.DEPTH(FIFO_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (o_push),
		.wdata (o_item),
		.full  (o_full),
		.pop   (pop),
		.rdata (o_rdata),
		.empty (empty)
	);

	assign o_head    = o_rdata;
	assign character = o_head.character;
	assign last      = o_head.last;

endmodule
`default_nettype wire

### sim/itoa_text_checker.sv
// Checker for the integer to ASCII converter: predicts each value's text and compares results.
`timescale 1ns / 1ps
module itoa_text_checker
	import itoa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic              full,
	input  wire logic [31:0]       value,
	input  wire logic              pop,
	input  wire logic              empty,
	input  wire logic [7:0]        character,
	input  wire logic              last,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	input  wire logic              pready,
	output int                     mismatches,
	output int                     pending_results
);

	localparam int DIGIT_SLOTS    = 32;
	localparam int DECIMAL_DIGITS = 10;

	// Characters still owed by the block, oldest first
	out_item_t expected_text[$];
	logic [RADIX_W-1:0] radix_shadow;

	initial begin
		mismatches      = 0;
		pending_results = 0;
		radix_shadow    = RADIX_RESET;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] text check: %s", $time, msg);
		mismatches++;
	endtask

	// Append the expected characters of one value in the current radix
	function automatic void convert_value(input logic [31:0] v);
		logic [5:0]  digits [DIGIT_SLOTS];
		logic [31:0] mag;
		int unsigned base;
		int          count;
		out_item_t   item;
		base = radix_shadow;
		if (base < RADIX_MIN)
			base = RADIX_MIN;
		if (base > RADIX_MAX)
			base = RADIX_MAX;
		// magnitude as unsigned, so the most negative value works
		mag = v[31] ? (~v + 32'd1) : v;
		count = 0;
		do begin
			digits[count] = 6'(mag % base);
			mag = mag / base;
			count++;
		end while (mag != 0 && count < DIGIT_SLOTS);
		if (v[31]) begin
			item.character = CHAR_MINUS;
			item.last      = 1'b0;
			expected_text.push_back(item);
		end
		for (int i = count - 1; i >= 0; i--) begin
			if (digits[i] < DECIMAL_DIGITS)
				item.character = CHAR_ZERO + 8'(digits[i]);
			else
				item.character = CHAR_LETTER_A + 8'(digits[i]) - 8'(DECIMAL_DIGITS);
			item.last = (i == 0);
			expected_text.push_back(item);
		end
	endfunction

	// Watch all three channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			expected_text.delete();
			radix_shadow    = RADIX_RESET;
			pending_results = 0;
		end else begin
			// result transaction: compare with the oldest expectation
			if (pop && !empty) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected result char=0x%02h last=%0b",
						character, last));
				end else begin
					want = expected_text.pop_front();
					if (character !== want.character)
						report_mismatch($sformatf("character: expected 0x%02h, got 0x%02h",
							want.character, character));
					if (last !== want.last)
						report_mismatch($sformatf("last: expected %0b, got %0b (char 0x%02h)",
							want.last, last, want.character));
				end
			end
			// register write transaction
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_RADIX)
				radix_shadow = pwdata[RADIX_W-1:0];
			// input transaction
			if (push && !full)
				convert_value(value);
			pending_results = expected_text.size();
		end
	end

endmodule

### sim/testbench.sv
// Testbench top: drives values and radix writes into the converter and gives the verdict.
`timescale 1ns / 1ps
module testbench;
	import itoa_pkg::*;

	localparam int IDLE_LIMIT   = 20000;
	localparam int TAIL_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 39;
	localparam int PHASE_COUNT  = 8;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic [31:0]       value;
	logic              full;
	logic              pop;
	logic              empty;
	logic [7:0]        character;
	logic              last;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int mismatches;
	int pending_results;
	int send_idle_pct;
	int recv_stall_pct;

	// Handshake outcomes of the last rising edge, read at the falling edge
	logic in_taken;
	logic out_taken;
	logic cfg_taken;

	integer_to_ascii_radix dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.value     (value),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.character (character),
		.last      (last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	itoa_text_checker text_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.value           (value),
		.pop             (pop),
		.empty           (empty),
		.character       (character),
		.last            (last),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.mismatches      (mismatches),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		in_taken  <= push & ~full;
		out_taken <= pop & ~empty;
		cfg_taken <= psel & penable & pwrite & pready;
	end

	// Receiver: random stalls on pop
	always @(negedge clk)
		pop <= ($urandom_range(99) >= recv_stall_pct);

	// Watchdog on cycles with no input or result transaction
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(negedge clk);
			if (in_taken || out_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// Idle modes: none, sender idle, receiver stalling, both
	task automatic set_pace(input int mode);
		case (mode)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 86;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 86;
			end
			default: begin
				send_idle_pct  = 24;
				recv_stall_pct = 24;
			end
		endcase
	endtask

	// One input transaction; push stays high if the next one follows at once
	task automatic send_value(input logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push  <= 1'b1;
		value <= v;
		do @(negedge clk); while (!in_taken);
	endtask

	// Stop sending and wait until every expected character has come back
	task automatic drain;
		push <= 1'b0;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);
	endtask

	// Register write, setup then access; upper data bits carry noise
	task automatic set_radix(input logic [RADIX_W-1:0] r);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_RADIX, 2'b00};
		pwdata  <= ($urandom & ~DATA_W'({RADIX_W{1'b1}})) | DATA_W'(r);
		@(negedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!cfg_taken);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mix of magnitudes so short and long texts both show up
	function automatic logic [31:0] random_value();
		logic [31:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4:          v = $urandom_range(1500);
			5:          v = -$urandom_range(1500);
			6: begin
				case ($urandom_range(3))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7fff_ffff;
					2:       v = 32'hffff_ffff;
					default: v = 32'h0;
				endcase
			end
			7:          v = ($urandom_range(1) != 0) ? (32'd1 << $urandom_range(31))
			                                         : -(32'd1 << $urandom_range(31));
			default:    v = $urandom >> $urandom_range(31);
		endcase
		return v;
	endfunction

	initial begin : stimulus
		logic [RADIX_W-1:0] radix_plan [PHASE_COUNT];
		radix_plan = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd0, 6'd63, 6'd7, 6'd0};
		radix_plan[PHASE_COUNT-1] = RADIX_W'($urandom_range(63));

		arst_n  = 1'b0;
		push    = 1'b0;
		value   = '0;
		pop     = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		set_pace(0);
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: decimal at the reset radix, zero and the extremes
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'hffff_ffff);
		send_value(32'h7fff_ffff);
		send_value(32'h8000_0000);
		send_value(32'd10);
		send_value(-32'd10);
		send_value(32'd9);
		// binary: the longest text, a minus sign and 32 digits
		drain;
		set_radix(6'd2);
		send_value(32'h8000_0000);
		send_value(32'h7fff_ffff);
		send_value(32'd0);
		send_value(32'hffff_ffff);
		// base 36: letters up to 'z'
		drain;
		set_radix(RADIX_MAX);
		send_value(32'd35);
		send_value(32'd36);
		send_value(32'd1295);
		send_value(32'h8000_0000);
		send_value(32'h7fff_ffff);
		// radix below two saturates to two
		drain;
		set_radix(6'd1);
		send_value(32'd5);
		send_value(-32'd6);
		// radix above thirty-six saturates to thirty-six
		drain;
		set_radix(6'd37);
		send_value(32'd71);
		send_value(-32'd1296);

		// Random phases over several radix settings and idle modes
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain;
			set_radix(radix_plan[p]);
			set_pace(p % 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				send_value(random_value());
				// sender holds off until the block has fully drained
				if (p == 1 && k == PHASE_ITEMS / 2)
					drain;
			end
		end

		drain;
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
sv/itoa_pkg.sv
sv/itoa_ram.sv
sv/itoa_fifo.sv
sv/itoa_front.sv
sv/itoa_divider.sv
sv/itoa_back.sv
sv/integer_to_ascii_radix.sv
sim/itoa_text_checker.sv
sim/testbench.sv
